// ===== hdl/scbe_pkg.sv =====
package scbe_pkg;

  localparam int BYTE_W    = 8;
  localparam int BLK_BYTES = 16;
  localparam int IDX_W     = $clog2(BLK_BYTES);
  localparam int PAD_W     = IDX_W + 1;

  // x' = (1103515245*x + 12345) mod 256 keeps only the low bytes of both constants
  localparam logic [BYTE_W-1:0] LCG_MUL8 = 8'h6D;
  localparam logic [BYTE_W-1:0] LCG_INC  = 8'h39;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index = paddr >> 2
  localparam logic [APB_AW-3:0] REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IV,
    S_BYTE,
    S_PAD,
    S_KEY,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

endpackage

// ===== hdl/scbe_in_if.sv =====
interface scbe_in_if;
  import scbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] plain_byte;
  logic              byte_valid;
  logic              message_end;

  modport source(output valid, plain_byte, byte_valid, message_end, input ready);
  modport sink(input valid, plain_byte, byte_valid, message_end, output ready);

endinterface

// ===== hdl/scbe_out_if.sv =====
interface scbe_out_if;
  import scbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] cipher_byte;
  logic              block_last;
  logic              message_last;

  modport source(output valid, cipher_byte, block_last, message_last, input ready);
  modport sink(input valid, cipher_byte, block_last, message_last, output ready);

endinterface

// ===== hdl/scbe_ram.sv =====
// One write port, two registered read ports, read-first on a same-address write.
module scbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== hdl/scbe_lcg.sv =====
// One step of the byte LCG; shared by IV and key generation.
module scbe_lcg (
  input  logic [scbe_pkg::BYTE_W-1:0] cur,
  output logic [scbe_pkg::BYTE_W-1:0] nxt
);
  import scbe_pkg::*;

  logic [2*BYTE_W-1:0] prod;

  assign prod = (2*BYTE_W)'(cur) * (2*BYTE_W)'(LCG_MUL8);
  assign nxt  = prod[BYTE_W-1:0] + LCG_INC;

endmodule

// ===== hdl/scbe_cfg.sv =====
// APB register bank: seed byte only.
module scbe_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scbe_pkg::APB_AW-1:0] paddr,
  input  logic [scbe_pkg::APB_DW-1:0] pwdata,
  output logic [scbe_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [scbe_pkg::BYTE_W-1:0] seed
);
  import scbe_pkg::*;

  logic [APB_AW-3:0] reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (wr_en && reg_idx == REG_SEED) begin
      seed <= pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SEED) begin
      prdata = APB_DW'(seed);
    end
  end

endmodule

// ===== hdl/shuffle_cbc_block_encrypt.sv =====
// Channel  Dir   Handshake       Word
// plain    in    valid/ready     plain_byte[8], byte_valid, message_end
// cipher   out   valid/ready     cipher_byte[8], block_last, message_last
// apb      cfg   psel/penable    seed_byte at byte address 0 (write/read)
//
// Sequence: a data word is absorbed through S_IDLE and S_BYTE. A full block then runs
//   key generation through the single LCG unit, swaps (S_SWAP_RD, S_SWAP_WA, S_SWAP_WB
//   for each key byte, on the block RAM's one write port) and S_OUT_RD, S_OUT_LD per
//   output word. The first word of a message adds IV generation in S_IV; padding
//   writes one pad word per S_PAD step.
// Reset: rst clears the sequencer, the fill count, the message flag and the output valid.
// Stalls: input is taken only in S_IDLE; a stalled output word holds the sequencer in
//   S_OUT_LD.
module shuffle_cbc_block_encrypt (
  input  logic                        clk,
  input  logic                        rst,
  scbe_in_if.sink                     plain,
  scbe_out_if.source                  cipher,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scbe_pkg::APB_AW-1:0] paddr,
  input  logic [scbe_pkg::APB_DW-1:0] pwdata,
  output logic [scbe_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import scbe_pkg::*;

  state_t state, state_next;

  // sequencer registers
  logic [IDX_W-1:0]  step;        // IV / key / swap / output index
  logic [IDX_W-1:0]  fill;        // words held in the current block
  logic [PAD_W-1:0]  pad_val;     // PKCS7 pad value, 1..16
  logic              in_message;
  logic              end_pend;    // current word carried message_end
  logic              final_blk;   // block in flight is the message's last

  // latched input word
  logic [BYTE_W-1:0] item_byte;
  logic              item_valid;

  // keystream and chaining
  logic [BYTE_W-1:0] lcg_value;
  logic [BYTE_W-1:0] lcg_nxt;
  logic [BYTE_W-1:0] chain [BLK_BYTES];
  logic [BYTE_W-1:0] key   [BLK_BYTES];
  logic [BYTE_W-1:0] seed;

  // output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_blast;
  logic              out_mlast;

  // block RAM holds data ^ chain, shuffled in place
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr_a;
  logic [IDX_W-1:0]  ram_raddr_b;
  logic [BYTE_W-1:0] ram_rdata_a;
  logic [BYTE_W-1:0] ram_rdata_b;

  logic              in_accept;
  logic              in_real;     // word with data or end marker
  logic              out_load;
  logic [BYTE_W-1:0] cipher_c;
  logic [IDX_W-1:0]  fill_inc;
  logic              blk_full;

  scbe_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .seed   (seed)
  );

  scbe_lcg u_lcg (
    .cur(lcg_value),
    .nxt(lcg_nxt)
  );

  scbe_ram #(
    .Width(BYTE_W),
    .Depth(BLK_BYTES)
  ) u_blk_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .raddr_b(ram_raddr_b),
    .rdata_a(ram_rdata_a),
    .rdata_b(ram_rdata_b)
  );

  assign in_accept = plain.valid && plain.ready;
  assign in_real   = plain.byte_valid || plain.message_end;
  assign cipher_c  = ram_rdata_a ^ key[step];
  assign fill_inc  = fill + IDX_W'(item_valid);
  assign blk_full  = item_valid && (fill == IDX_W'(BLK_BYTES - 1));

  assign cipher.valid        = out_valid;
  assign cipher.cipher_byte  = out_byte;
  assign cipher.block_last   = out_blast;
  assign cipher.message_last = out_mlast;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && in_real) begin
          state_next = in_message ? S_BYTE : S_IV;
        end
      end
      S_IV: begin
        if (step == IDX_W'(BLK_BYTES - 1)) begin
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        if (blk_full) begin
          state_next = S_KEY;
        end else if (end_pend) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD: begin
        if (fill == IDX_W'(BLK_BYTES - 1)) begin
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        if (step == IDX_W'(BLK_BYTES - 1)) begin
          state_next = S_SWAP_RD;
        end
      end
      S_SWAP_RD: state_next = S_SWAP_WA;
      S_SWAP_WA: state_next = S_SWAP_WB;
      S_SWAP_WB: begin
        state_next = (step == IDX_W'(BLK_BYTES - 1)) ? S_OUT_RD : S_SWAP_RD;
      end
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: begin
        if (out_load) begin
          if (step != IDX_W'(BLK_BYTES - 1)) begin
            state_next = S_OUT_RD;
          end else if (!final_blk && end_pend) begin
            state_next = S_PAD;   // block completed by the end word: pad block follows
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    plain.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = fill;
    ram_wdata   = item_byte ^ chain[fill];
    ram_raddr_a = step;
    ram_raddr_b = step;
    out_load    = 1'b0;
    unique case (state)
      S_IDLE: plain.ready = 1'b1;
      S_BYTE: ram_we = item_valid;
      S_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_W'(pad_val) ^ chain[fill];
      end
      // swap t[lo] and t[hi]; the read-first RAM still shows the old t[lo] during WB
      S_SWAP_RD, S_SWAP_WA, S_SWAP_WB: begin
        ram_raddr_a = key[step][IDX_W-1:0];
        ram_raddr_b = key[step][BYTE_W-1:IDX_W];
        if (state == S_SWAP_WA) begin
          ram_we    = 1'b1;
          ram_waddr = key[step][IDX_W-1:0];
          ram_wdata = ram_rdata_b;
        end else if (state == S_SWAP_WB) begin
          ram_we    = 1'b1;
          ram_waddr = key[step][BYTE_W-1:IDX_W];
          ram_wdata = ram_rdata_a;
        end
      end
      S_OUT_LD: out_load = !out_valid || cipher.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      fill       <= '0;
      in_message <= 1'b0;
      end_pend   <= 1'b0;
      final_blk  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (cipher.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept && in_real) begin
            item_byte  <= plain.plain_byte;
            item_valid <= plain.byte_valid;
            end_pend   <= plain.message_end;
            final_blk  <= 1'b0;
            if (!in_message) begin
              lcg_value  <= seed;
              fill       <= '0;
              in_message <= 1'b1;
            end
          end
        end
        S_IV: begin
          lcg_value   <= lcg_nxt;
          chain[step] <= lcg_nxt;
          step        <= step + 1'b1;
        end
        S_BYTE: begin
          fill <= fill_inc;
          if (!blk_full && end_pend) begin
            pad_val <= PAD_W'(BLK_BYTES) - PAD_W'(fill_inc);
          end
        end
        S_PAD: begin
          fill <= fill + 1'b1;
          if (fill == IDX_W'(BLK_BYTES - 1)) begin
            final_blk <= 1'b1;
            end_pend  <= 1'b0;
          end
        end
        S_KEY: begin
          lcg_value <= lcg_nxt;
          key[step] <= lcg_nxt;
          step      <= step + 1'b1;
        end
        S_SWAP_WB: step <= step + 1'b1;
        S_OUT_LD: begin
          if (out_load) begin
            chain[step] <= cipher_c;
            out_byte    <= cipher_c;
            out_blast   <= (step == IDX_W'(BLK_BYTES - 1));
            out_mlast   <= final_blk && (step == IDX_W'(BLK_BYTES - 1));
            step        <= step + 1'b1;
            if (step == IDX_W'(BLK_BYTES - 1)) begin
              if (final_blk) begin
                in_message <= 1'b0;
              end else if (end_pend) begin
                pad_val <= PAD_W'(BLK_BYTES);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_mlast_blast: assert property (@(posedge clk) disable iff (rst)
    cipher.valid && cipher.message_last |-> cipher.block_last)
    else $error("message_last without block_last");

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PAD |-> pad_val != '0 && pad_val <= PAD_W'(BLK_BYTES))
    else $error("pad value out of range");

  a_busy_in_msg: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_message)
    else $error("sequencer busy outside a message");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(cipher.valid) |-> $past(state) == S_OUT_LD)
    else $error("output word loaded outside output phase");

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scbe_pkg::*;

  // run limits; the slowest case is a word that closes a block with a full pad block
  // behind it, under the slowest receiver
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CFG_SETTLE  = 64;   // covers IV load plus a word in flight
  localparam int END_SETTLE  = 400;  // room for one stray block to show up

  localparam logic [APB_AW-1:0] SEED_ADDR = {REG_SEED, 2'b00};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              blk_last;
    logic              msg_last;
  } cipher_word_t;

  logic clk = 1'b0;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scbe_in_if  plain_ch();
  scbe_out_if cipher_ch();

  shuffle_cbc_block_encrypt i_dut (
    .clk     (clk),
    .rst     (rst),
    .plain   (plain_ch),
    .cipher  (cipher_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor: own copy of the seed register, chain, data block,
  // keystream position, fill count and message-open flag.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] seed_reg;
  logic [BYTE_W-1:0] chain_blk [BLK_BYTES];
  logic [BYTE_W-1:0] data_blk  [BLK_BYTES];
  logic [BYTE_W-1:0] ks_state;
  int                fill_cnt;
  bit                msg_open;

  cipher_word_t expected_cipher[$];

  int errors;
  int words_sent;
  int words_checked;
  int messages_sent;
  int seeds_used;
  int cycles;

  int src_idle_pct;
  int snk_idle_pct;
  int snk_stall_left;

  // x' = (1103515245*x + 12345) mod 256, done in full 32-bit math
  function automatic logic [BYTE_W-1:0] keystream_next(input logic [BYTE_W-1:0] x);
    logic [31:0] v;
    v = 32'd1103515245 * {24'd0, x} + 32'd12345;
    return v[BYTE_W-1:0];
  endfunction

  // IV = first 16 keystream bytes from the seed; keys continue from there
  function automatic void load_chain_iv();
    logic [BYTE_W-1:0] x;
    x = seed_reg;
    for (int i = 0; i < BLK_BYTES; i++) begin
      x = keystream_next(x);
      chain_blk[i] = x;
    end
    ks_state = x;
  endfunction

  // chain XOR, 16 nibble-pair swaps in key order, key XOR; queue 16 words
  function automatic void encrypt_block(input bit closes_msg);
    logic [BYTE_W-1:0] t [BLK_BYTES];
    logic [BYTE_W-1:0] k [BLK_BYTES];
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [BYTE_W-1:0] s;
    cipher_word_t      w;
    for (int i = 0; i < BLK_BYTES; i++)
      t[i] = data_blk[i] ^ chain_blk[i];
    for (int i = 0; i < BLK_BYTES; i++) begin
      ks_state = keystream_next(ks_state);
      k[i] = ks_state;
    end
    for (int i = 0; i < BLK_BYTES; i++) begin
      a = k[i][3:0];
      b = k[i][7:4];
      s = t[a];
      t[a] = t[b];
      t[b] = s;
    end
    for (int i = 0; i < BLK_BYTES; i++) begin
      w.data     = t[i] ^ k[i];
      w.blk_last = (i == BLK_BYTES - 1);
      w.msg_last = closes_msg && (i == BLK_BYTES - 1);
      chain_blk[i] = w.data;
      expected_cipher.push_back(w);
    end
  endfunction

  function automatic void absorb_word(input logic [BYTE_W-1:0] pb, input logic bv,
                                      input logic me);
    int                used;
    logic [BYTE_W-1:0] pad;
    if (!bv && !me)
      return;
    if (!msg_open) begin
      load_chain_iv();
      fill_cnt = 0;
      msg_open = 1'b1;
    end
    if (bv) begin
      data_blk[fill_cnt % BLK_BYTES] = pb;
      fill_cnt++;
      if (fill_cnt >= BLK_BYTES) begin
        encrypt_block(1'b0);
        fill_cnt = 0;
      end
    end
    if (me) begin
      // PKCS7 style: an empty tail gets a whole block of 16
      used = fill_cnt % BLK_BYTES;
      pad  = BYTE_W'(BLK_BYTES - used);
      for (int i = used; i < BLK_BYTES; i++)
        data_blk[i] = pad;
      encrypt_block(1'b1);
      fill_cnt = 0;
      msg_open = 1'b0;
      messages_sent++;
    end
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10)
      $display("%0t ns: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Cipher side: random ready bursts at the falling edge, checks at the rising
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (snk_stall_left > 0) begin
      cipher_ch.ready = 1'b0;
      snk_stall_left = snk_stall_left - 1;
    end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
      cipher_ch.ready = 1'b0;
      snk_stall_left = $urandom_range(0, 8);
    end else begin
      cipher_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cipher_word_t exp_w;
    if (!rst && cipher_ch.valid && cipher_ch.ready) begin
      if (expected_cipher.size() == 0) begin
        note_error($sformatf("unexpected cipher word: data=%02h blk_last=%0b msg_last=%0b",
                             cipher_ch.cipher_byte, cipher_ch.block_last,
                             cipher_ch.message_last));
      end else begin
        exp_w = expected_cipher.pop_front();
        words_checked++;
        if (cipher_ch.cipher_byte !== exp_w.data)
          note_error($sformatf("cipher_byte: expected %02h, got %02h",
                               exp_w.data, cipher_ch.cipher_byte));
        if (cipher_ch.block_last !== exp_w.blk_last)
          note_error($sformatf("block_last: expected %0b, got %0b",
                               exp_w.blk_last, cipher_ch.block_last));
        if (cipher_ch.message_last !== exp_w.msg_last)
          note_error($sformatf("message_last: expected %0b, got %0b",
                               exp_w.msg_last, cipher_ch.message_last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, expected_cipher.size());
      $display("** shuffle_cbc_block_encrypt: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Plain side. Valid stays high after an accept so back-to-back words go
  // out without a bubble; anything that is not a send drops it first.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [BYTE_W-1:0] pb, input logic bv, input logic me);
    int gap;
    @(negedge clk);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 9);
      plain_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    plain_ch.plain_byte  = pb;
    plain_ch.byte_valid  = bv;
    plain_ch.message_end = me;
    plain_ch.valid       = 1'b1;
    @(posedge clk);
    while (!plain_ch.ready) @(posedge clk);
    absorb_word(pb, bv, me);
    if (bv || me)
      words_sent++;
  endtask

  // hold off until every expected word is back, then let the block settle
  task automatic drain(input int settle);
    @(negedge clk);
    plain_ch.valid = 1'b0;
    while (expected_cipher.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write_seed(input logic [BYTE_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SEED_ADDR;
    pwdata  = APB_DW'(val);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seed_reg = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check_seed();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = SEED_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(seed_reg))
      note_error($sformatf("seed readback: expected %08h, got %08h",
                           APB_DW'(seed_reg), prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // writes only with the block idle: drains the plain side and lets it settle first
  task automatic set_seed(input logic [BYTE_W-1:0] val);
    drain(CFG_SETTLE);
    apb_write_seed(val);
    apb_check_seed();
    seeds_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset seed reads back as 0; bare end marker on an empty message gives one
  // pad block of 16s under the reset IV; an idle word is dropped
  task automatic test_reset_and_bare_end();
    apb_check_seed();
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
  endtask

  // byte that fills a block arrives with the end flag: block plus pad block
  task automatic test_block_with_end();
    for (int i = 0; i < BLK_BYTES; i++) begin
      case (i)
        0:       send_word(8'h00, 1'b1, 1'b0);
        1:       send_word(8'hFF, 1'b1, 1'b0);
        15:      send_word(8'hFF, 1'b1, 1'b1);
        default: send_word(BYTE_W'($urandom), 1'b1, 1'b0);
      endcase
    end
  endtask

  // top seed, then a seed write in the middle of an open message: it must
  // only apply from the next message on
  task automatic test_seed_extremes_and_mid_message();
    set_seed(8'hFF);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h3C, 1'b1, 1'b0);
    set_seed(8'h5A);
    send_word(8'hC3, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h81, 1'b1, 1'b1);
  endtask

  // mostly whole messages with random content and lengths around block
  // edges; some idle words and empty messages as noise
  task automatic test_random_messages(input int n_words, input logic [BYTE_W-1:0] seed,
                                      input bit mid_seed);
    int  len;
    int  r;
    int  start;
    bit  bare_end;
    bit  did_mid;
    set_seed(seed);
    start   = words_sent;
    did_mid = 1'b0;
    while (words_sent - start < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        len = 0;
      else if (r < 25)
        len = $urandom_range(0, 1) ? 16 : 32;
      else if (r < 35)
        len = $urandom_range(0, 1) ? 15 : 31;
      else
        len = $urandom_range(1, 40);
      bare_end = (len == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_word(BYTE_W'($urandom), 1'b0, 1'b0);
        if (mid_seed && !did_mid && len >= 4 && i == len / 2) begin
          set_seed(BYTE_W'($urandom));
          did_mid = 1'b1;
        end
        send_word(BYTE_W'($urandom), 1'b1, !bare_end && (i == len - 1));
      end
      if (bare_end)
        send_word(BYTE_W'($urandom), 1'b0, 1'b1);
    end
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    plain_ch.valid        = 1'b0;
    plain_ch.plain_byte   = '0;
    plain_ch.byte_valid   = 1'b0;
    plain_ch.message_end  = 1'b0;
    cipher_ch.ready       = 1'b0;
    src_idle_pct          = 0;
    snk_idle_pct          = 0;
    snk_stall_left        = 0;
    errors                = 0;
    words_sent            = 0;
    words_checked         = 0;
    messages_sent         = 0;
    seeds_used            = 1;
    cycles                = 0;

    // predictor reset: seed 0, IV loaded, nothing open
    seed_reg = '0;
    fill_cnt = 0;
    msg_open = 1'b0;
    for (int i = 0; i < BLK_BYTES; i++)
      data_blk[i] = '0;
    load_chain_iv();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 20;
    snk_idle_pct = 20;
    test_reset_and_bare_end();
    test_block_with_end();
    test_seed_extremes_and_mid_message();

    // phases with different idle mixes; the last one runs flat out
    src_idle_pct = 30;
    snk_idle_pct = 30;
    test_random_messages(50, BYTE_W'($urandom), 1'b1);
    src_idle_pct = 5;
    snk_idle_pct = 50;
    test_random_messages(50, 8'h00, 1'b0);
    src_idle_pct = 50;
    snk_idle_pct = 5;
    test_random_messages(50, 8'hFF, 1'b1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_messages(50, BYTE_W'($urandom), 1'b0);

    drain(END_SETTLE);
    if (expected_cipher.size() != 0)
      note_error($sformatf("%0d cipher words never arrived", expected_cipher.size()));

    $display("covered %0d plain words in %0d messages under %0d seed settings",
             words_sent, messages_sent, seeds_used);
    $display("checked %0d cipher words, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("** shuffle_cbc_block_encrypt: PASSED **");
    end else begin
      $display("** shuffle_cbc_block_encrypt: FAILED **");
    end
    $finish;
  end

endmodule
